/* hdl/asm_lex_pkg.sv */
// asm_lex_pkg: types, character codes and helpers for the assembly line lexer
// no dependencies, used by assembly_line_lexer_top

package asm_lex_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned EV_W    = 2;
    localparam int unsigned TT_W    = 3;
    localparam int unsigned MAX_RES = 3;

    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [EV_W-1:0] EV_BYTE    = 2'd0;
    localparam logic [EV_W-1:0] EV_CLOSE   = 2'd1;
    localparam logic [EV_W-1:0] EV_QUOTE   = 2'd2;
    localparam logic [EV_W-1:0] EV_UNKNOWN = 2'd3;

    localparam logic [TT_W-1:0] TT_IDENT  = 3'd0;
    localparam logic [TT_W-1:0] TT_NUMBER = 3'd1;
    localparam logic [TT_W-1:0] TT_STRING = 3'd2;
    localparam logic [TT_W-1:0] TT_COMMA  = 3'd3;
    localparam logic [TT_W-1:0] TT_COLON  = 3'd4;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_STRING  = 5'b01000,
        MODE_DISCARD = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [TT_W-1:0]   tt;
        logic [CHAR_W-1:0] data;
    } t_result;

    function automatic t_result mk_result(input logic [EV_W-1:0] ev,
                                          input logic [TT_W-1:0] tt,
                                          input logic [CHAR_W-1:0] data);
        t_result r;
        r.ev   = ev;
        r.tt   = tt;
        r.data = data;
        return r;
    endfunction

    function automatic logic is_alpha_u(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

/* hdl/assembly_line_lexer_top.sv */
// assembly_line_lexer_top: streaming lexer for lines of assembly source
// depends on asm_lex_pkg for codes, mode type and character classes
//
// slave channel: one source character per word, tlast marks the last
// character of a line. master channel: one lexer event per word, tdata is
// the token byte, tuser carries event and token type, tlast marks the
// final event caused by a character.
// a character is held in an input register; its events (up to three) are
// worked out there and moved one per cycle into the output register while
// the receiver accepts. the first event of a character is loaded into the
// output register once that register is empty or being read. a character
// causes n (0 to 3) events; the output register can deliver only one
// event per cycle, and only while the receiver accepts.
// the next character is taken in the cycle its predecessor hands over its
// last event, also while that event still waits in the output register.
// reset empties both registers and returns the lexer to idle between
// tokens. when the receiver stalls, the output word holds and the input
// stops taking characters once the pending events back up.

module assembly_line_lexer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // ch
    input  logic       i_s_axis_tlast,   // end_of_line
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // token_byte
    output logic [4:0] o_m_axis_tuser,   // event_res, token_type
    output logic       o_m_axis_tlast    // last
);

    logic                           r_in_valid;
    logic [asm_lex_pkg::CHAR_W-1:0] r_ch;
    logic                           r_eol;
    logic [1:0]                     r_idx;
    asm_lex_pkg::t_mode             r_mode;

    logic                           r_out_valid;
    asm_lex_pkg::t_result           r_out;
    logic                           r_out_last;

    asm_lex_pkg::t_result           w_res [0:asm_lex_pkg::MAX_RES-1];
    logic [1:0]                     w_count;
    asm_lex_pkg::t_mode             n_mode;
    logic                           w_load;
    logic                           w_final;
    logic                           w_done;
    logic                           w_in_acc;

    // events of the held character
    always_comb begin
        logic [1:0]         v_n;
        asm_lex_pkg::t_mode v_mode;
        v_n    = 2'd0;
        v_mode = r_mode;
        for (int i = 0; i < asm_lex_pkg::MAX_RES; i++) begin
            w_res[i] = '0;
        end
        case (r_mode)
            asm_lex_pkg::MODE_IDLE,
            asm_lex_pkg::MODE_IDENT,
            asm_lex_pkg::MODE_NUMBER,
            asm_lex_pkg::MODE_STRING,
            asm_lex_pkg::MODE_DISCARD: v_mode = r_mode;
            default:                   v_mode = asm_lex_pkg::MODE_IDLE;
        endcase

        if (v_mode == asm_lex_pkg::MODE_STRING) begin
            if (r_ch == asm_lex_pkg::CH_QUOTE) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_STRING, asm_lex_pkg::CH_NUL);
                v_n    = v_n + 2'd1;
                v_mode = asm_lex_pkg::MODE_IDLE;
            end else begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                    asm_lex_pkg::TT_STRING, r_ch);
                v_n = v_n + 2'd1;
            end
        end else if (v_mode == asm_lex_pkg::MODE_DISCARD) begin
            v_n = 2'd0;
        end else if (v_mode == asm_lex_pkg::MODE_IDENT &&
                     (asm_lex_pkg::is_alpha_u(r_ch) || asm_lex_pkg::is_digit(r_ch))) begin
            w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                asm_lex_pkg::TT_IDENT, r_ch);
            v_n = v_n + 2'd1;
        end else if (v_mode == asm_lex_pkg::MODE_NUMBER && asm_lex_pkg::is_digit(r_ch)) begin
            w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                asm_lex_pkg::TT_NUMBER, r_ch);
            v_n = v_n + 2'd1;
        end else begin
            // close an open identifier or number first
            if (v_mode == asm_lex_pkg::MODE_IDENT) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_IDENT, asm_lex_pkg::CH_NUL);
                v_n    = v_n + 2'd1;
                v_mode = asm_lex_pkg::MODE_IDLE;
            end else if (v_mode == asm_lex_pkg::MODE_NUMBER) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_NUMBER, asm_lex_pkg::CH_NUL);
                v_n    = v_n + 2'd1;
                v_mode = asm_lex_pkg::MODE_IDLE;
            end
            if (asm_lex_pkg::is_alpha_u(r_ch)) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                    asm_lex_pkg::TT_IDENT, r_ch);
                v_n    = v_n + 2'd1;
                v_mode = asm_lex_pkg::MODE_IDENT;
            end else if (asm_lex_pkg::is_digit(r_ch) || r_ch == asm_lex_pkg::CH_PLUS ||
                         r_ch == asm_lex_pkg::CH_MINUS) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                    asm_lex_pkg::TT_NUMBER, r_ch);
                v_n    = v_n + 2'd1;
                v_mode = asm_lex_pkg::MODE_NUMBER;
            end else if (r_ch == asm_lex_pkg::CH_QUOTE) begin
                v_mode = asm_lex_pkg::MODE_STRING;
            end else if (r_ch == asm_lex_pkg::CH_SPACE || r_ch == asm_lex_pkg::CH_TAB) begin
                v_mode = v_mode;
            end else if (r_ch == asm_lex_pkg::CH_COMMA) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                    asm_lex_pkg::TT_COMMA, r_ch);
                v_n = v_n + 2'd1;
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_COMMA, asm_lex_pkg::CH_NUL);
                v_n = v_n + 2'd1;
            end else if (r_ch == asm_lex_pkg::CH_COLON) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_BYTE,
                    asm_lex_pkg::TT_COLON, r_ch);
                v_n = v_n + 2'd1;
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_COLON, asm_lex_pkg::CH_NUL);
                v_n = v_n + 2'd1;
            end else if (r_ch == asm_lex_pkg::CH_SEMI) begin
                v_mode = asm_lex_pkg::MODE_DISCARD;
            end else begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_UNKNOWN,
                    asm_lex_pkg::TT_IDENT, r_ch);
                v_n    = v_n + 2'd1;
                v_mode = asm_lex_pkg::MODE_DISCARD;
            end
        end

        // end of line closes what is open
        if (r_eol) begin
            if (v_mode == asm_lex_pkg::MODE_IDENT) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_IDENT, asm_lex_pkg::CH_NUL);
                v_n = v_n + 2'd1;
            end else if (v_mode == asm_lex_pkg::MODE_NUMBER) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_CLOSE,
                    asm_lex_pkg::TT_NUMBER, asm_lex_pkg::CH_NUL);
                v_n = v_n + 2'd1;
            end else if (v_mode == asm_lex_pkg::MODE_STRING) begin
                w_res[v_n] = asm_lex_pkg::mk_result(asm_lex_pkg::EV_QUOTE,
                    asm_lex_pkg::TT_STRING, asm_lex_pkg::CH_QUOTE);
                v_n = v_n + 2'd1;
            end
            v_mode = asm_lex_pkg::MODE_IDLE;
        end

        w_count = v_n;
        n_mode  = v_mode;
    end

    assign w_load   = r_in_valid && (w_count != 2'd0) && (!r_out_valid || i_m_axis_tready);
    assign w_final  = (r_idx == (w_count - 2'd1));
    assign w_done   = r_in_valid && ((w_count == 2'd0) || (w_load && w_final));
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= 2'd0;
            r_mode     <= asm_lex_pkg::MODE_IDLE;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_done) begin
                r_in_valid <= 1'b0;
            end
            if (w_done) begin
                r_idx  <= 2'd0;
                r_mode <= n_mode;
            end else if (w_load) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch  <= i_s_axis_tdata;
            r_eol <= i_s_axis_tlast;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out      <= w_res[r_idx];
            r_out_last <= w_final;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = {r_out.tt, r_out.ev};
    assign o_m_axis_tlast  = r_out_last;

    a_idx_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> (r_idx == 2'd0))
        else $error("event index not cleared while input register empty");

    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_idx != 2'd0)) |-> (r_idx < w_count))
        else $error("event index past event count");

    a_close_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.ev == asm_lex_pkg::EV_CLOSE)) |-> (r_out.data == asm_lex_pkg::CH_NUL))
        else $error("close event with nonzero byte");

    a_quote_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.ev == asm_lex_pkg::EV_QUOTE)) |-> r_out_last)
        else $error("unmatched quote error not final event of its character");

endmodule
